FILE: rtl/bvo_pkg.sv
// Package for the BVH box overlap query block: command codes, field widths,
// default sizes. No dependencies.
`default_nettype none
package bvo_pkg;
    localparam int CMD_W    = 3;
    localparam int ID_W     = 10;
    localparam int SLOT_W   = 10;
    localparam int CNT_W    = 11;
    localparam int IN_W     = 32;
    localparam int APB_DW   = 32;
    localparam int PADDR_W  = 3;

    localparam int DEF_MAX_LEAVES  = 1024;
    localparam int DEF_NODE_SLOTS  = 2048;
    localparam int DEF_COORD_BITS  = 32;
    localparam int DEF_STACK_DEPTH = 11;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_BUILD = 3'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

    localparam logic [CNT_W-1:0] TC_RESET = 11'd1;
    localparam int REG_TRI_COUNT = 0;
endpackage
`default_nettype wire

FILE: rtl/bvo_ram.sv
// Simple dual-port synchronous RAM, one write port, one registered read port.
// No dependencies.
`default_nettype none
module bvo_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic                 i_re,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

FILE: rtl/bvh_box_overlap_query.sv
// Top level of the BVH box overlap query block: command sequencer, walk stack,
// APB register. Depends on bvo_pkg and bvo_ram.
//
//   channel   | signals                                  | transfer
//   ----------+------------------------------------------+-------------------------------
//   command   | start, busy, i_cmd .. i_box_max_z        | start high while busy low
//   result    | o_valid, o_answer, o_status              | o_valid high, one cycle
//   register  | psel penable pwrite paddr pwdata prdata  | psel&penable&pwrite (pready=1)
//
// Steps: load leaf descends the tree to the leaf node of its slot, read flag
// reads the flag memory, unknown codes reply straight from idle. A query pops
// and checks each node (QPOP, QCHK), and a matched leaf adds an id read (QLEAF).
// A build handles each inner node with two child reads, one write back, stack handling.
// Clear flags sweeps the flag memory, one entry per cycle.
// After reset the same sweep runs; busy stays high until it ends.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module bvh_box_overlap_query #(
    parameter int MAX_LEAVES  = bvo_pkg::DEF_MAX_LEAVES,
    parameter int NODE_SLOTS  = bvo_pkg::DEF_NODE_SLOTS,
    parameter int COORD_BITS  = bvo_pkg::DEF_COORD_BITS,
    parameter int STACK_DEPTH = bvo_pkg::DEF_STACK_DEPTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bvo_pkg::PADDR_W-1:0] paddr,
    input  wire logic [bvo_pkg::APB_DW-1:0]  pwdata,
    output logic      [bvo_pkg::APB_DW-1:0]  prdata,
    output logic                             pready,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [bvo_pkg::CMD_W-1:0]   i_cmd,
    input  wire logic [bvo_pkg::SLOT_W-1:0]  i_slot,
    input  wire logic [bvo_pkg::ID_W-1:0]    i_triangle_id,
    input  wire logic [bvo_pkg::ID_W-1:0]    i_compare_id,
    input  wire logic                        i_same_object,
    input  wire logic signed [bvo_pkg::IN_W-1:0] i_box_min_x,
    input  wire logic signed [bvo_pkg::IN_W-1:0] i_box_min_y,
    input  wire logic signed [bvo_pkg::IN_W-1:0] i_box_min_z,
    input  wire logic signed [bvo_pkg::IN_W-1:0] i_box_max_x,
    input  wire logic signed [bvo_pkg::IN_W-1:0] i_box_max_y,
    input  wire logic signed [bvo_pkg::IN_W-1:0] i_box_max_z,
    output logic                             o_valid,
    output logic                             o_answer,
    output logic                             o_status
);
    import bvo_pkg::*;

    // widths
    localparam int CB   = COORD_BITS;
    localparam int BW   = 6 * CB;                    // packed box
    localparam int NA   = $clog2(NODE_SLOTS);        // node memory address
    localparam int NW   = NA + 1;                    // node index incl. overflow
    localparam int CW   = $clog2(MAX_LEAVES + 1);    // leaf bound b, e
    localparam int FAW  = $clog2(MAX_LEAVES);        // leaf / flag address
    localparam int SDB  = 2 * STACK_DEPTH;           // build walk needs ancestors too
    localparam int SIW  = $clog2(SDB);
    localparam int SPW  = $clog2(SDB + 1);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_LDESC = 4'd2;
    localparam logic [3:0] S_FRD   = 4'd3;
    localparam logic [3:0] S_QPOP  = 4'd4;
    localparam logic [3:0] S_QCHK  = 4'd5;
    localparam logic [3:0] S_QLEAF = 4'd6;
    localparam logic [3:0] S_BPOP  = 4'd7;
    localparam logic [3:0] S_BRDL  = 4'd8;
    localparam logic [3:0] S_BRDR  = 4'd9;

    // keep the low COORD_BITS bits as the coordinate key
    function automatic logic [CB-1:0] to_coord(input logic [IN_W-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[CB-1:0];
    endfunction

    function automatic logic signed [CB-1:0] axis(input logic [BW-1:0] bx, input int k);
        return $signed(bx[(5 - k) * CB +: CB]);
    endfunction

    // ------------------------------------------------------------------
    // registers
    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_tc;
    logic [CMD_W-1:0] r_cmd, n_cmd;
    logic [BW-1:0]    r_q, n_q;
    logic [ID_W-1:0]  r_cmp, n_cmp, r_tid, n_tid;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic             r_same, n_same;
    logic [NW-1:0]    r_n, n_n;
    logic [CW-1:0]    r_b, n_b, r_e, n_e;
    logic             r_any, n_any;
    logic [SPW-1:0]   r_sp, n_sp;
    logic [BW-1:0]    r_left, n_left;
    logic [FAW-1:0]   r_clr_idx, n_clr_idx;
    logic             r_clr_reply, n_clr_reply;
    logic             r_valid, n_valid;
    logic             r_answer, n_answer, r_status, n_status;

    // walk stack, entries {node, b, e, expanded}
    logic [NW-1:0] r_stk_n [SDB];
    logic [CW-1:0] r_stk_b [SDB];
    logic [CW-1:0] r_stk_e [SDB];
    logic          r_stk_x [SDB];

    // push requests
    logic [1:0]    push_cnt;
    logic [SPW-1:0] push_base;
    int            push_lim;
    logic [NW-1:0] p_n [3];
    logic [CW-1:0] p_b [3];
    logic [CW-1:0] p_e [3];
    logic          p_x [3];

    // memory ports
    logic             node_we, node_re, id_we, id_re, flg_we, flg_re;
    logic [NA-1:0]    node_waddr, node_raddr;
    logic [BW-1:0]    node_wdata, node_rdata;
    logic [FAW-1:0]   id_waddr, id_raddr, flg_waddr, flg_raddr;
    logic [ID_W-1:0]  id_rdata;
    logic             flg_wdata, flg_rdata;

    // misc combinational
    logic [CW-1:0]    eff;
    logic [CW-1:0]    diff, mid, top_b, top_e, top_diff, top_mid;
    logic [NW-1:0]    top_n;
    logic             top_x;
    logic [SIW-1:0]   top_idx;
    logic             overlap;
    logic [BW-1:0]    comb_box;
    logic [BW-1:0]    in_box;
    logic             cfg_wr;

    bvo_ram #(.W(BW), .D(NODE_SLOTS)) u_node_mem (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(node_waddr), .i_wdata(node_wdata),
        .i_re(node_re), .i_raddr(node_raddr), .o_rdata(node_rdata)
    );

    bvo_ram #(.W(ID_W), .D(MAX_LEAVES)) u_id_mem (
        .i_clk(i_clk), .i_we(id_we), .i_waddr(id_waddr), .i_wdata(r_tid),
        .i_re(id_re), .i_raddr(id_raddr), .o_rdata(id_rdata)
    );

    bvo_ram #(.W(1), .D(MAX_LEAVES)) u_flag_mem (
        .i_clk(i_clk), .i_we(flg_we), .i_waddr(flg_waddr), .i_wdata(flg_wdata),
        .i_re(flg_re), .i_raddr(flg_raddr), .o_rdata(flg_rdata)
    );

    // ------------------------------------------------------------------
    // APB register
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == 1'b0) ? APB_DW'(r_tc) : '0;

    // effective leaf count: 0 acts as 1, clipped at MAX_LEAVES
    always_comb begin
        if (r_tc == '0) begin
            eff = CW'(1);
        end else if (32'(r_tc) > MAX_LEAVES) begin
            eff = CW'(MAX_LEAVES);
        end else begin
            eff = CW'(r_tc);
        end
    end

    assign in_box = {to_coord(i_box_min_x), to_coord(i_box_min_y), to_coord(i_box_min_z),
                     to_coord(i_box_max_x), to_coord(i_box_max_y), to_coord(i_box_max_z)};

    // stack top
    assign top_idx  = SIW'(r_sp - SPW'(1));
    assign top_n    = r_stk_n[top_idx];
    assign top_b    = r_stk_b[top_idx];
    assign top_e    = r_stk_e[top_idx];
    assign top_x    = r_stk_x[top_idx];
    assign top_diff = top_e - top_b;
    assign top_mid  = top_b + (top_diff >> 1);
    assign diff     = r_e - r_b;
    assign mid      = r_b + (diff >> 1);

    // inclusive overlap of query box and node box just read
    always_comb begin
        overlap = 1'b1;
        for (int a = 0; a < 3; a++) begin
            if (axis(r_q, a) > axis(node_rdata, a + 3)) overlap = 1'b0;
            if (axis(r_q, a + 3) < axis(node_rdata, a)) overlap = 1'b0;
        end
    end

    // parent box from the latched left child and the right child just read
    always_comb begin
        comb_box = '0;
        for (int a = 0; a < 3; a++) begin
            comb_box[(5 - a) * CB +: CB] = (axis(r_left, a) < axis(node_rdata, a)) ?
                r_left[(5 - a) * CB +: CB] : node_rdata[(5 - a) * CB +: CB];
            comb_box[(2 - a) * CB +: CB] = (axis(r_left, a + 3) > axis(node_rdata, a + 3)) ?
                r_left[(2 - a) * CB +: CB] : node_rdata[(2 - a) * CB +: CB];
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_q         = r_q;
        n_cmp       = r_cmp;
        n_tid       = r_tid;
        n_slot      = r_slot;
        n_same      = r_same;
        n_n         = r_n;
        n_b         = r_b;
        n_e         = r_e;
        n_any       = r_any;
        n_sp        = r_sp;
        n_left      = r_left;
        n_clr_idx   = r_clr_idx;
        n_clr_reply = r_clr_reply;
        n_valid     = 1'b0;
        n_answer    = r_answer;
        n_status    = r_status;
        push_cnt    = 2'd0;
        push_base   = r_sp;
        for (int j = 0; j < 3; j++) begin
            p_n[j] = '0;
            p_b[j] = '0;
            p_e[j] = '0;
            p_x[j] = 1'b0;
        end
        node_we    = 1'b0;
        node_waddr = r_n[NA-1:0];
        node_wdata = r_q;
        node_re    = 1'b0;
        node_raddr = top_n[NA-1:0];
        id_we      = 1'b0;
        id_waddr   = FAW'(r_slot);
        id_re      = 1'b0;
        id_raddr   = FAW'(r_b);
        flg_we     = 1'b0;
        flg_waddr  = r_clr_idx;
        flg_wdata  = 1'b0;
        flg_re     = 1'b0;
        flg_raddr  = FAW'(i_triangle_id);

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd  = i_cmd;
                    n_q    = in_box;
                    n_cmp  = i_compare_id;
                    n_tid  = i_triangle_id;
                    n_slot = i_slot;
                    n_same = i_same_object;
                    case (i_cmd)
                        CMD_LOAD: begin
                            if (32'(i_slot) >= 32'(eff) || 32'(i_triangle_id) >= 32'(eff)) begin
                                n_valid = 1'b1; n_answer = 1'b0; n_status = 1'b1;
                            end else begin
                                n_n = NW'(1); n_b = '0; n_e = eff;
                                n_state = S_LDESC;
                            end
                        end
                        CMD_BUILD, CMD_QUERY: begin
                            push_base = '0;
                            push_cnt  = 2'd1;
                            p_n[0] = NW'(1); p_b[0] = '0; p_e[0] = eff; p_x[0] = 1'b0;
                            n_any   = 1'b0;
                            n_state = (i_cmd == CMD_QUERY) ? S_QPOP : S_BPOP;
                        end
                        CMD_READ: begin
                            if (32'(i_triangle_id) >= 32'(eff)) begin
                                n_valid = 1'b1; n_answer = 1'b0; n_status = 1'b1;
                            end else begin
                                flg_re  = 1'b1;
                                n_state = S_FRD;
                            end
                        end
                        CMD_CLEAR: begin
                            n_clr_idx   = '0;
                            n_clr_reply = 1'b1;
                            n_state     = S_CLR;
                        end
                        default: begin
                            n_valid = 1'b1; n_answer = 1'b0; n_status = 1'b0;
                        end
                    endcase
                end
            end
            S_CLR: begin
                flg_we = 1'b1;
                if (r_clr_idx == FAW'(MAX_LEAVES - 1)) begin
                    n_state = S_IDLE;
                    if (r_clr_reply) begin
                        n_valid = 1'b1; n_answer = 1'b0; n_status = 1'b0;
                    end
                    n_clr_reply = 1'b0;
                end else begin
                    n_clr_idx = r_clr_idx + FAW'(1);
                end
            end
            S_LDESC: begin
                // one tree level per cycle towards the leaf node of this slot
                if (diff > CW'(1) && 32'(r_n) < NODE_SLOTS) begin
                    if (32'(r_slot) < 32'(mid)) begin
                        n_n = {r_n[NW-2:0], 1'b0}; n_e = mid;
                    end else begin
                        n_n = {r_n[NW-2:0], 1'b1}; n_b = mid;
                    end
                end else begin
                    node_we = (32'(r_n) < NODE_SLOTS);
                    id_we   = 1'b1;
                    n_valid = 1'b1; n_answer = 1'b0; n_status = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_FRD: begin
                n_valid = 1'b1; n_answer = flg_rdata; n_status = 1'b0;
                n_state = S_IDLE;
            end
            S_QPOP: begin
                if (r_sp == '0) begin
                    n_valid = 1'b1; n_answer = r_any; n_status = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_sp = r_sp - SPW'(1);
                    n_n  = top_n;
                    n_b  = top_b;
                    n_e  = top_e;
                    if (32'(top_n) < NODE_SLOTS) begin
                        node_re = 1'b1;
                        n_state = S_QCHK;
                    end
                end
            end
            S_QCHK: begin
                n_state = S_QPOP;
                if (overlap) begin
                    if (diff <= CW'(1)) begin
                        if (32'(r_b) < MAX_LEAVES) begin
                            id_re   = 1'b1;
                            n_state = S_QLEAF;
                        end
                    end else begin
                        // right first so the left child is walked next
                        push_cnt = 2'd2;
                        p_n[0] = {r_n[NW-2:0], 1'b1}; p_b[0] = mid; p_e[0] = r_e;
                        p_n[1] = {r_n[NW-2:0], 1'b0}; p_b[1] = r_b; p_e[1] = mid;
                    end
                end
            end
            S_QLEAF: begin
                n_state = S_QPOP;
                if (!(r_same && id_rdata == r_cmp)) begin
                    flg_we    = (32'(id_rdata) < MAX_LEAVES);
                    flg_waddr = FAW'(id_rdata);
                    flg_wdata = 1'b1;
                    n_any     = 1'b1;
                end
            end
            S_BPOP: begin
                if (r_sp == '0) begin
                    n_valid = 1'b1; n_answer = 1'b0; n_status = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_sp      = r_sp - SPW'(1);
                    push_base = r_sp - SPW'(1);
                    if (!top_x) begin
                        if (top_diff > CW'(1) && 32'({top_n[NW-2:0], 1'b1}) < NODE_SLOTS) begin
                            // revisit this node once both children are done
                            push_cnt = 2'd3;
                            p_n[0] = top_n; p_b[0] = top_b; p_e[0] = top_e; p_x[0] = 1'b1;
                            p_n[1] = {top_n[NW-2:0], 1'b1}; p_b[1] = top_mid; p_e[1] = top_e;
                            p_n[2] = {top_n[NW-2:0], 1'b0}; p_b[2] = top_b; p_e[2] = top_mid;
                        end
                    end else begin
                        n_n        = top_n;
                        node_re    = 1'b1;
                        node_raddr = {top_n[NA-2:0], 1'b0};
                        n_state    = S_BRDL;
                    end
                end
            end
            S_BRDL: begin
                n_left     = node_rdata;
                node_re    = 1'b1;
                node_raddr = {r_n[NA-2:0], 1'b1};
                n_state    = S_BRDR;
            end
            S_BRDR: begin
                node_we    = 1'b1;
                node_wdata = comb_box;
                n_state    = S_BPOP;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // entries that do not fit are dropped
        push_lim = (n_cmd == CMD_QUERY) ? STACK_DEPTH : SDB;
        for (int j = 0; j < 3; j++) begin
            if (j < 32'(push_cnt) && 32'(push_base) + j < push_lim) begin
                n_sp = SPW'(32'(push_base) + j + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            if (j < 32'(push_cnt) && 32'(push_base) + j < push_lim) begin
                r_stk_n[SIW'(32'(push_base) + j)] <= p_n[j];
                r_stk_b[SIW'(32'(push_base) + j)] <= p_b[j];
                r_stk_e[SIW'(32'(push_base) + j)] <= p_e[j];
                r_stk_x[SIW'(32'(push_base) + j)] <= p_x[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_tc        <= TC_RESET;
            r_sp        <= '0;
            r_clr_idx   <= '0;
            r_clr_reply <= 1'b0;
            r_valid     <= 1'b0;
            r_cmd       <= CMD_LOAD;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_clr_idx   <= n_clr_idx;
            r_clr_reply <= n_clr_reply;
            r_valid     <= n_valid;
            r_cmd       <= n_cmd;
            if (cfg_wr && paddr[2] == 1'b0) begin
                r_tc <= pwdata[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q      <= n_q;
        r_cmp    <= n_cmp;
        r_tid    <= n_tid;
        r_slot   <= n_slot;
        r_same   <= n_same;
        r_n      <= n_n;
        r_b      <= n_b;
        r_e      <= n_e;
        r_any    <= n_any;
        r_left   <= n_left;
        r_answer <= n_answer;
        r_status <= n_status;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_answer = r_answer;
    assign o_status = r_status;
endmodule
`default_nettype wire
